// ===== src/vctb_pkg.sv =====
package vctb_pkg;

    // bank size and derived widths
    localparam int TIMER_COUNT = 8;
    localparam int ADDR_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    // fixed field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 3;
    localparam int DUR_W   = 32;
    localparam int STEP_W  = 16;
    localparam int MASK_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register map: one 32-bit register per word, selected by paddr[2]
    localparam int   REG_SEL_BIT      = 2;
    localparam logic REG_TICK_STEP    = 1'b0;
    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd1;

    // operation codes; codes above OP_QUERY behave as a query
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_IDLE_ALL = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        TS_IDLE    = 2'd0,
        TS_ACTIVE  = 2'd1,
        TS_EXPIRED = 2'd2
    } tstate_t;

    typedef struct packed {
        tstate_t           state;
        logic [DUR_W-1:0]  remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ENG_IDLE   = 2'd0,
        ENG_MODIFY = 2'd1,
        ENG_DONE   = 2'd2
    } eng_state_t;

    // new value of one timer entry under an operation
    function automatic entry_t timer_update(
        input logic [OP_W-1:0]   op,
        input entry_t            cur,
        input logic [STEP_W-1:0] step,
        input logic [DUR_W-1:0]  dur
    );
        entry_t           nxt;
        logic [DUR_W-1:0] step_ext;
        nxt      = cur;
        step_ext = {{(DUR_W-STEP_W){1'b0}}, step};
        unique case (op)
            OP_TICK:
            begin
                if (cur.state == TS_ACTIVE)
                begin
                    if (cur.remaining < step_ext)
                        nxt.state = TS_EXPIRED;
                    else
                        nxt.remaining = cur.remaining - step_ext;
                end
            end
            OP_START:
            begin
                nxt.state     = TS_ACTIVE;
                nxt.remaining = dur;
            end
            OP_STOP, OP_IDLE_ALL:
            begin
                nxt.state = TS_IDLE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

// ===== src/vctb_ram.sv =====
module vctb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/vctb_regs.sv =====
module vctb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vctb_pkg::PADDR_W-1:0]       paddr,
    input  logic [vctb_pkg::PDATA_W-1:0]       pwdata,
    output logic [vctb_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    output logic [vctb_pkg::STEP_W-1:0]        tick_step
);

    logic [vctb_pkg::STEP_W-1:0] tick_step_reg;
    logic                        sel_step;

    assign sel_step = (paddr[vctb_pkg::REG_SEL_BIT] == vctb_pkg::REG_TICK_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_step_reg <= vctb_pkg::TICK_STEP_RESET;
        else if (psel && penable && pwrite && sel_step)
            tick_step_reg <= pwdata[vctb_pkg::STEP_W-1:0];
    end

    always_comb
    begin
        if (sel_step)
            prdata = {{(vctb_pkg::PDATA_W-vctb_pkg::STEP_W){1'b0}}, tick_step_reg};
        else
            prdata = '0;
    end

    assign pready    = 1'b1;
    assign tick_step = tick_step_reg;

endmodule

// ===== src/vctb_engine.sv =====
module vctb_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [vctb_pkg::STEP_W-1:0]       tick_step,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [vctb_pkg::OP_W-1:0]         op,
    input  logic [vctb_pkg::IDX_W-1:0]        timer_index,
    input  logic [vctb_pkg::DUR_W-1:0]        duration,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        addressed_state,
    output logic [vctb_pkg::DUR_W-1:0]        addressed_remaining,
    output logic [vctb_pkg::MASK_W-1:0]       expired_mask,
    output vctb_pkg::ram_req_t                ram_req,
    input  vctb_pkg::entry_t                  ram_rd_data
);

    localparam int AW = vctb_pkg::ADDR_W;
    localparam int WW = vctb_pkg::IDX_W + vctb_pkg::ADDR_W;

    vctb_pkg::eng_state_t state_reg, state_next;

    logic [vctb_pkg::OP_W-1:0]   op_reg;
    logic [vctb_pkg::DUR_W-1:0]  dur_reg;
    logic [AW-1:0]               tgt_addr_reg;
    logic                        tgt_valid_reg;
    logic                        wr_ok_reg;
    logic [AW-1:0]               ptr_reg;
    logic [AW-1:0]               last_reg;
    logic [vctb_pkg::TIMER_COUNT-1:0] entry_valid_reg;
    logic [vctb_pkg::TIMER_COUNT-1:0] expired_reg;
    vctb_pkg::entry_t            res_reg;

    logic                        out_valid_reg;
    vctb_pkg::entry_t            out_entry_reg;
    logic [vctb_pkg::MASK_W-1:0] out_mask_reg;

    logic [WW-1:0]               idx_wide;
    logic [AW-1:0]               in_addr;
    logic                        in_idx_ok;
    logic                        in_sweep;
    logic [AW-1:0]               in_first;
    logic [AW-1:0]               in_last;
    logic                        accept;
    logic                        at_last;
    logic                        hit;
    logic                        wr_go;
    logic                        done_go;
    vctb_pkg::entry_t            cur_entry;
    vctb_pkg::entry_t            new_entry;
    logic [vctb_pkg::MASK_W-1:0] mask_now;

    // input decode
    assign idx_wide  = {{AW{1'b0}}, timer_index};
    assign in_addr   = idx_wide[AW-1:0];
    assign in_idx_ok = (idx_wide < WW'(vctb_pkg::TIMER_COUNT));
    assign in_sweep  = (op == vctb_pkg::OP_TICK) || (op == vctb_pkg::OP_IDLE_ALL);
    assign in_first  = in_sweep ? '0 : in_addr;
    assign in_last   = in_sweep ? AW'(vctb_pkg::TIMER_COUNT - 1) : in_addr;

    assign accept  = (state_reg == vctb_pkg::ENG_IDLE) && in_valid;
    assign at_last = (ptr_reg == last_reg);
    assign hit     = tgt_valid_reg && (ptr_reg == tgt_addr_reg);
    assign wr_go   = (state_reg == vctb_pkg::ENG_MODIFY) && wr_ok_reg;
    assign done_go = (state_reg == vctb_pkg::ENG_DONE) && (!out_valid_reg || !out_stall);

    // entry never written reads as idle with a zero count
    assign cur_entry = entry_valid_reg[ptr_reg] ? ram_rd_data : '0;
    assign new_entry = vctb_pkg::timer_update(op_reg, cur_entry, tick_step, dur_reg);

    for (genvar i = 0; i < vctb_pkg::MASK_W; i++)
    begin : g_mask
        if (i < vctb_pkg::TIMER_COUNT)
        begin : g_on
            assign mask_now[i] = expired_reg[i];
        end
        else
        begin : g_off
            assign mask_now[i] = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vctb_pkg::ENG_IDLE:
            begin
                if (accept)
                    state_next = vctb_pkg::ENG_MODIFY;
            end
            vctb_pkg::ENG_MODIFY:
            begin
                if (at_last)
                    state_next = vctb_pkg::ENG_DONE;
            end
            vctb_pkg::ENG_DONE:
            begin
                if (done_go)
                    state_next = vctb_pkg::ENG_IDLE;
            end
            default:
            begin
                state_next = vctb_pkg::ENG_IDLE;
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        ram_req         = '0;
        ram_req.wr_en   = wr_go;
        ram_req.wr_addr = ptr_reg;
        ram_req.wr_data = new_entry;
        unique case (state_reg)
            vctb_pkg::ENG_IDLE:
            begin
                ram_req.rd_en   = accept;
                ram_req.rd_addr = in_first;
            end
            vctb_pkg::ENG_MODIFY:
            begin
                ram_req.rd_en   = !at_last;
                ram_req.rd_addr = ptr_reg + 1'b1;
            end
            default:
            begin
                ram_req.rd_en   = 1'b0;
                ram_req.rd_addr = ptr_reg;
            end
        endcase
    end

    assign in_stall = (state_reg != vctb_pkg::ENG_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vctb_pkg::ENG_IDLE;
            entry_valid_reg <= '0;
            expired_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_go)
            begin
                entry_valid_reg[ptr_reg] <= 1'b1;
                expired_reg[ptr_reg]     <= (new_entry.state == vctb_pkg::TS_EXPIRED);
            end
            if (done_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // transaction context and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            dur_reg       <= duration;
            tgt_addr_reg  <= in_addr;
            tgt_valid_reg <= in_idx_ok;
            wr_ok_reg     <= in_idx_ok || in_sweep;
            ptr_reg       <= in_first;
            last_reg      <= in_last;
            res_reg       <= '0;
        end
        else if (state_reg == vctb_pkg::ENG_MODIFY)
        begin
            if (hit)
                res_reg <= new_entry;
            if (!at_last)
                ptr_reg <= ptr_reg + 1'b1;
        end
        if (done_go)
        begin
            out_entry_reg <= res_reg;
            out_mask_reg  <= mask_now;
        end
    end

    assign out_valid           = out_valid_reg;
    assign addressed_state     = out_entry_reg.state;
    assign addressed_remaining = out_entry_reg.remaining;
    assign expired_mask        = out_mask_reg;

endmodule

// ===== src/virtual_countdown_timer_bank.sv =====
// sequence: an accepted transaction reads, updates and writes back its entries in the modify state,
//   then raises out_valid from the done state; tick and set-all-idle sweep the whole bank
// throughput: one transaction at a time, in_stall stays high until the engine is idle again;
//   the timer memory has one read and one write port, and modify handles one entry per cycle
// reset: rst_n clears all timers to idle with zero count (per-entry written flags),
//   tick_step returns to 1; no clearing pass is needed
module virtual_countdown_timer_bank (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vctb_pkg::PADDR_W-1:0]      paddr,
    input  logic [vctb_pkg::PDATA_W-1:0]      pwdata,
    output logic [vctb_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,

    // command channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [vctb_pkg::OP_W-1:0]         op,
    input  logic [vctb_pkg::IDX_W-1:0]        timer_index,
    input  logic [vctb_pkg::DUR_W-1:0]        duration,

    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        addressed_state,
    output logic [vctb_pkg::DUR_W-1:0]        addressed_remaining,
    output logic [vctb_pkg::MASK_W-1:0]       expired_mask
);

    // shared tick step, to be written by the user only while the bank is quiet; the block does not enforce it
    logic [vctb_pkg::STEP_W-1:0] tick_step;

    // memory request from the engine and registered read data back
    vctb_pkg::ram_req_t          ram_req;
    logic [vctb_pkg::ENTRY_W-1:0] ram_rd_bits;
    vctb_pkg::entry_t            ram_rd_data;

    vctb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tick_step (tick_step)
    );

    // one entry per timer: state and remaining count packed together
    vctb_ram #(
        .WIDTH (vctb_pkg::ENTRY_W),
        .DEPTH (vctb_pkg::TIMER_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_bits)
    );

    assign ram_rd_data = vctb_pkg::entry_t'(ram_rd_bits);

    // sequencer: reads an entry, updates it the next cycle and writes it back while
    // the following entry is read, so a sweep never touches the same entry twice at once
    vctb_engine u_engine (
        .clk                 (clk),
        .rst_n               (rst_n),
        .tick_step           (tick_step),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .op                  (op),
        .timer_index         (timer_index),
        .duration            (duration),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .addressed_state     (addressed_state),
        .addressed_remaining (addressed_remaining),
        .expired_mask        (expired_mask),
        .ram_req             (ram_req),
        .ram_rd_data         (ram_rd_data)
    );

endmodule

// ===== sim/virtual_countdown_timer_bank_tb.sv =====
`timescale 1ns / 100ps

module virtual_countdown_timer_bank_tb;

    import vctb_pkg::*;

    // register map and op codes past the defined set
    localparam int TICK_STEP_REG = 0;
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_QUERY + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    // settle time after draining: covers a full bank sweep with margin on top
    localparam int BANK_SETTLE = TIMER_COUNT + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 125;

    typedef struct {
        logic [OP_W-1:0]  code;
        logic [IDX_W-1:0] idx;
        logic [DUR_W-1:0] dur;
    } timer_cmd_t;

    typedef struct {
        logic [1:0]        state;
        logic [DUR_W-1:0]  remaining;
        logic [MASK_W-1:0] mask;
    } timer_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op = '0;
    logic [IDX_W-1:0]    timer_index = '0;
    logic [DUR_W-1:0]    duration = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          addressed_state;
    logic [DUR_W-1:0]    addressed_remaining;
    logic [MASK_W-1:0]   expired_mask;

    // our own copy of the bank and its tick step
    tstate_t             bank_state [TIMER_COUNT];
    logic [DUR_W-1:0]    bank_count [TIMER_COUNT];
    logic [STEP_W-1:0]   tick_step_cfg;

    timer_cmd_t          cmd_pending [$];
    timer_status_t       status_due [$];

    // idle percentages, changed per phase by the sequencer
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int fail_count = 0;
    int cycle_count = 0;
    int cmds_taken = 0;
    int results_checked = 0;
    int ticks_taken = 0;
    int starts_taken = 0;
    int expirations = 0;
    int step_writes = 0;

    virtual_countdown_timer_bank uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .op                  (op),
        .timer_index         (timer_index),
        .duration            (duration),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .addressed_state     (addressed_state),
        .addressed_remaining (addressed_remaining),
        .expired_mask        (expired_mask)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, status_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // apply one command to the shadow bank, return the status it reports
    function automatic timer_status_t apply_to_bank(
        input logic [OP_W-1:0]  code,
        input logic [IDX_W-1:0] idx,
        input logic [DUR_W-1:0] dur
    );
        timer_status_t    res;
        logic [DUR_W-1:0] step_ext;
        bit               hit;
        int               i;
        hit = (idx < TIMER_COUNT);
        step_ext = {{(DUR_W-STEP_W){1'b0}}, tick_step_cfg};
        case (code)
            OP_TICK:
            begin
                ticks_taken++;
                for (i = 0; i < TIMER_COUNT; i++)
                begin
                    if (bank_state[i] == TS_ACTIVE)
                    begin
                        // count below the step: expire and keep the count
                        if (bank_count[i] < step_ext)
                        begin
                            bank_state[i] = TS_EXPIRED;
                            expirations++;
                        end
                        else
                            bank_count[i] = bank_count[i] - step_ext;
                    end
                end
            end
            OP_START:
            begin
                starts_taken++;
                if (hit)
                begin
                    bank_state[idx] = TS_ACTIVE;
                    bank_count[idx] = dur;
                end
            end
            OP_STOP:
            begin
                // counts survive a stop, only the state goes idle
                if (hit)
                    bank_state[idx] = TS_IDLE;
            end
            OP_IDLE_ALL:
            begin
                for (i = 0; i < TIMER_COUNT; i++)
                    bank_state[i] = TS_IDLE;
            end
            default:
            begin
                // query and the spare codes leave the bank alone
            end
        endcase
        res.state = hit ? bank_state[idx] : TS_IDLE;
        res.remaining = hit ? bank_count[idx] : '0;
        res.mask = '0;
        for (i = 0; i < TIMER_COUNT && i < MASK_W; i++)
            if (bank_state[i] == TS_EXPIRED)
                res.mask[i] = 1'b1;
        return res;
    endfunction

    // driver: takes the next command off the pending queue when the
    // channel is free, and predicts the status of each accepted transaction
    always @(posedge clk)
    begin : cmd_driver
        logic       nxt_valid;
        timer_cmd_t cmd;
        nxt_valid = in_valid;
        if (in_valid && !in_stall)
        begin
            status_due.push_back(apply_to_bank(op, timer_index, duration));
            cmds_taken++;
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && rst_n && cmd_pending.size() > 0
            && $urandom_range(99) >= send_idle_pct)
        begin
            cmd = cmd_pending.pop_front();
            op <= cmd.code;
            timer_index <= cmd.idx;
            duration <= cmd.dur;
            nxt_valid = 1'b1;
        end
        in_valid <= nxt_valid;
    end

    // monitor: checks each accepted result against the oldest prediction,
    // and stalls the result channel at random
    always @(posedge clk)
    begin : status_monitor
        timer_status_t want;
        if (out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                $error("result with nothing due: state %0d remaining %0d mask %02h",
                       addressed_state, addressed_remaining, expired_mask);
                fail_count++;
            end
            else
            begin
                want = status_due.pop_front();
                results_checked++;
                if (addressed_state !== want.state)
                begin
                    $error("addressed_state: expected %0d, actual %0d",
                           want.state, addressed_state);
                    fail_count++;
                end
                if (addressed_remaining !== want.remaining)
                begin
                    $error("addressed_remaining: expected %0d, actual %0d",
                           want.remaining, addressed_remaining);
                    fail_count++;
                end
                if (expired_mask !== want.mask)
                begin
                    $error("expired_mask: expected %02h, actual %02h",
                           want.mask, expired_mask);
                    fail_count++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    task automatic queue_cmd(
        input logic [OP_W-1:0]  code,
        input logic [IDX_W-1:0] idx,
        input logic [DUR_W-1:0] dur
    );
        timer_cmd_t cmd;
        cmd.code = code;
        cmd.idx = idx;
        cmd.dur = dur;
        cmd_pending.push_back(cmd);
    endtask

    // random command; durations cluster around small multiples of the step
    // so timers actually run out within a phase
    task automatic queue_random_cmd(input logic [STEP_W-1:0] step);
        logic [OP_W-1:0]  code;
        logic [DUR_W-1:0] dur;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 35)
            code = OP_TICK;
        else if (pick < 60)
            code = OP_START;
        else if (pick < 68)
            code = OP_STOP;
        else if (pick < 72)
            code = OP_IDLE_ALL;
        else if (pick < 90)
            code = OP_QUERY;
        else
            code = OP_SPARE_LO + OP_W'($urandom_range(OP_SPARE_HI - OP_SPARE_LO));
        case ($urandom_range(9))
            0:       dur = '0;
            1:       dur = '1;
            2, 3:    dur = $urandom;
            default:
            begin
                if (step == 0)
                    dur = $urandom_range(20);
                else
                    dur = step * $urandom_range(6) + $urandom_range(2) - 1;
            end
        endcase
        queue_cmd(code, IDX_W'($urandom_range(TIMER_COUNT - 1)), dur);
    endtask

    // wait until nothing is queued, in flight or due, then let the bank settle
    task automatic wait_drained;
        while (cmd_pending.size() != 0 || in_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (BANK_SETTLE) @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_tick_step(input logic [STEP_W-1:0] value);
        logic [PDATA_W-STEP_W-1:0] junk;
        junk = (PDATA_W-STEP_W)'($urandom);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * TICK_STEP_REG);
        // upper bits are not part of the register
        pwdata <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tick_step_cfg = value;
        step_writes++;
    endtask

    task automatic run_random_phase(
        input logic [STEP_W-1:0] step,
        input int                send_pct,
        input int                recv_pct
    );
        int n;
        wait_drained();
        write_tick_step(step);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            queue_random_cmd(step);
        // the sender holds off until every result is back before the next phase
        wait_drained();
    endtask

    // sequencer
    initial
    begin
        int i;
        for (i = 0; i < TIMER_COUNT; i++)
        begin
            bank_state[i] = TS_IDLE;
            bank_count[i] = '0;
        end
        tick_step_cfg = TICK_STEP_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, step of one, sender idles a little, receiver a lot
        write_tick_step(16'd1);
        send_idle_pct = 8;
        recv_idle_pct = 71;
        queue_cmd(OP_QUERY, 3'd0, '0);            // reset state
        queue_cmd(OP_START, 3'd0, '0);            // zero duration: expires on next tick
        queue_cmd(OP_START, 3'd1, 32'd1);
        queue_cmd(OP_START, 3'd7, '1);            // largest duration, top index
        queue_cmd(OP_START, 3'd2, 32'd2);
        queue_cmd(OP_TICK, 3'd0, '0);
        queue_cmd(OP_TICK, 3'd1, '0);             // count exactly reaches below step
        queue_cmd(OP_QUERY, 3'd0, '0);
        queue_cmd(OP_SPARE_LO, 3'd2, '1);         // spare codes act as a query
        queue_cmd(OP_SPARE_LO + 3'd1, 3'd7, 32'h1234_5678);
        queue_cmd(OP_SPARE_HI, 3'd1, '0);
        queue_cmd(OP_STOP, 3'd0, '1);             // expired to idle, count kept
        queue_cmd(OP_START, 3'd3, 32'd5);
        queue_cmd(OP_TICK, 3'd3, '0);
        queue_cmd(OP_IDLE_ALL, 3'd7, '0);         // all idle, counts kept
        queue_cmd(OP_QUERY, 3'd3, '0);
        queue_cmd(OP_TICK, 3'd3, '0);             // idle timers do not move
        queue_cmd(OP_START, 3'd4, 32'hAAAA_AAAA);
        queue_cmd(OP_START, 3'd5, 32'h5555_5555);
        queue_cmd(OP_START, 3'd6, 32'h8000_0000);
        queue_cmd(OP_STOP, 3'd6, '0);             // active to idle
        queue_cmd(OP_TICK, 3'd5, '0);
        queue_cmd(OP_QUERY, 3'd4, '0);

        // random phases through the step extremes and the idle patterns
        run_random_phase(16'hFFFF, 8, 71);
        run_random_phase(16'd0, 8, 71);           // step of zero freezes active counts
        run_random_phase(STEP_W'($urandom_range(2, 40)), 71, 8);
        run_random_phase(16'd1, 71, 8);
        run_random_phase(STEP_W'($urandom_range(41, 65534)), 0, 0);
        run_random_phase(16'd3, 0, 0);

        $display("covered %0d transactions (%0d ticks, %0d starts), %0d results checked",
                 cmds_taken, ticks_taken, starts_taken, results_checked);
        $display("%0d timer expirations seen across %0d tick step settings",
                 expirations, step_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/vctb_pkg.sv
src/vctb_ram.sv
src/vctb_regs.sv
src/vctb_engine.sv
src/virtual_countdown_timer_bank.sv
sim/virtual_countdown_timer_bank_tb.sv
